[rtl/brbcq_pkg.sv]
`timescale 1ns / 1ps

package brbcq_pkg;

    localparam int DEPTH_DEF = 4096;
    localparam int CHUNK_DEF = 8;
    localparam int AMT_W     = 12;
    localparam int CFG_W     = 13;
    localparam int CHUNK_W   = 64;
    localparam int CNT_W     = 12;

    // operation codes
    typedef enum logic [2:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_MOVR   = 3'd3,
        OP_MOVF   = 3'd4,
        OP_CLEAR  = 3'd5,
        OP_STATUS = 3'd6,
        OP_BAD    = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [AMT_W-1:0]   amount;
        logic [CHUNK_W-1:0] chunk_in;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic [CHUNK_W-1:0] chunk_out;
        logic [CNT_W-1:0]   used_count;
        logic [CNT_W-1:0]   free_count;
        logic [CNT_W-1:0]   contiguous_get;
        logic [CNT_W-1:0]   contiguous_put;
    } out_item_t;

    // decoded command from the front part
    typedef struct packed {
        op_t                op;
        logic [AMT_W-1:0]   amount;
        logic [CHUNK_W-1:0] chunk;
        logic               chunk_ok;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_MOD,
        ST_ADD,
        ST_FIN
    } state_t;

endpackage

[rtl/brbcq_front.sv]
`timescale 1ns / 1ps

module brbcq_front #(
    parameter int CHUNK_BYTES = brbcq_pkg::CHUNK_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  brbcq_pkg::in_item_t in_item,
    output logic                q_valid,
    output brbcq_pkg::cmd_t     q_cmd,
    input  logic                q_pop
);

    brbcq_pkg::cmd_t slot_reg [2];
    logic            rd_ptr_reg, rd_ptr_next;
    logic            wr_ptr_reg, wr_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    brbcq_pkg::cmd_t dec;
    logic            do_push, do_pop;

    // classify the incoming beat
    always_comb
    begin
        dec.op       = brbcq_pkg::op_t'(in_item.op);
        dec.amount   = in_item.amount;
        dec.chunk    = in_item.chunk_in;
        dec.chunk_ok = (in_item.amount <= brbcq_pkg::AMT_W'(CHUNK_BYTES));
    end

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    // pointer and count update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

[rtl/brbcq_back.sv]
`timescale 1ns / 1ps

module brbcq_back #(
    parameter int DEPTH       = brbcq_pkg::DEPTH_DEF,
    parameter int CHUNK_BYTES = brbcq_pkg::CHUNK_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  brbcq_pkg::cmd_t              q_cmd,
    output logic                         q_pop,
    input  logic                         cfg_we,
    input  logic [brbcq_pkg::CFG_W-1:0]  cfg_data,
    output logic                         idle,
    output logic                         empty,
    input  logic                         pop,
    output brbcq_pkg::out_item_t         out_item
);

    localparam int IW = $clog2(DEPTH);
    localparam int SW = IW + 1;
    localparam int LW = $clog2(CHUNK_BYTES + 1);
    localparam int CW = (SW > brbcq_pkg::CFG_W) ? SW : brbcq_pkg::CFG_W;
    localparam int STW = $clog2(brbcq_pkg::AMT_W);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;
    logic       mem_we;
    logic [IW-1:0] mem_addr;
    logic [7:0] mem_wdata;

    brbcq_pkg::state_t state_reg, state_next;
    brbcq_pkg::cmd_t   cmd_reg, cmd_next;
    logic [IW-1:0] f_reg, f_next, r_reg, r_next, pos_reg, pos_next, nidx_reg, nidx_next;
    logic [SW-1:0] size_reg, size_next, rem_reg, rem_next;
    logic [LW-1:0] cnt_reg, cnt_next, lane_reg, lane_next;
    logic [STW-1:0] step_reg, step_next;
    logic          pend_reg, pend_next, ok_reg, ok_next;
    logic [brbcq_pkg::CHUNK_W-1:0] chunk_reg, chunk_next;
    logic          outv_reg, outv_next;
    brbcq_pkg::out_item_t out_reg, out_next;

    logic [SW-1:0] fe, re, used, freeb, span_get, span_put;
    logic [CW-1:0] amt_c;
    logic [LW-1:0] amt_l;
    logic [SW:0]   tsum;
    logic [IW-1:0] pos_inc;
    logic [SW:0]   nsum;
    logic [SW-1:0] nwrap;

    // fill and span figures from the current indices
    always_comb
    begin
        fe    = SW'(f_reg);
        re    = SW'(r_reg);
        used  = (re > fe) ? (re - fe - SW'(1)) : (re + size_reg - fe - SW'(1));
        freeb = size_reg - SW'(1) - used;
        if (re > fe)
        begin
            span_get = re - fe - SW'(1);
            span_put = size_reg - re;
        end
        else
        begin
            span_get = (fe == size_reg - SW'(1)) ? re : (size_reg - fe - SW'(1));
            span_put = fe - re;
        end
    end

    assign amt_c   = CW'(q_cmd.amount);
    assign amt_l   = LW'(cmd_reg.amount);
    assign pos_inc = (SW'(pos_reg) + SW'(1) >= size_reg) ? '0 : (pos_reg + IW'(1));
    assign idle    = (state_reg == brbcq_pkg::ST_IDLE);
    assign empty   = !outv_reg;
    assign out_item = out_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        f_next     = f_reg;
        r_next     = r_reg;
        pos_next   = pos_reg;
        nidx_next  = nidx_reg;
        size_next  = size_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        lane_next  = lane_reg;
        step_next  = step_reg;
        pend_next  = 1'b0;
        ok_next    = ok_reg;
        chunk_next = chunk_reg;
        outv_next  = outv_reg && !pop;
        out_next   = out_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = pos_reg;
        mem_wdata  = cmd_reg.chunk[cnt_reg*8 +: 8];
        tsum       = '0;
        nsum       = '0;
        nwrap      = '0;

        case (state_reg)
            brbcq_pkg::ST_IDLE:
            begin
                if (q_valid && !cfg_we)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    chunk_next = '0;
                    cnt_next   = '0;
                    state_next = brbcq_pkg::ST_FIN;
                    case (q_cmd.op)
                        brbcq_pkg::OP_ENQ:
                        begin
                            ok_next  = q_cmd.chunk_ok && (amt_c <= CW'(freeb));
                            pos_next = r_reg;
                            if (ok_next && q_cmd.amount != '0)
                            begin
                                state_next = brbcq_pkg::ST_WRITE;
                            end
                        end
                        brbcq_pkg::OP_DEQ, brbcq_pkg::OP_PEEK:
                        begin
                            ok_next  = q_cmd.chunk_ok && (amt_c <= CW'(used));
                            pos_next = (fe + SW'(1) >= size_reg) ? '0 : (f_reg + IW'(1));
                            nsum     = (SW+1)'(fe) + (SW+1)'(q_cmd.amount[LW-1:0]);
                            nwrap    = (nsum >= (SW+1)'(size_reg))
                                       ? SW'(nsum - (SW+1)'(size_reg)) : SW'(nsum);
                            nidx_next = IW'(nwrap);
                            if (ok_next && q_cmd.amount != '0)
                            begin
                                state_next = brbcq_pkg::ST_READ;
                            end
                        end
                        brbcq_pkg::OP_MOVR, brbcq_pkg::OP_MOVF:
                        begin
                            ok_next    = 1'b1;
                            rem_next   = '0;
                            step_next  = '0;
                            state_next = brbcq_pkg::ST_MOD;
                        end
                        brbcq_pkg::OP_CLEAR:
                        begin
                            ok_next = 1'b1;
                            f_next  = '0;
                            r_next  = IW'(1);
                        end
                        brbcq_pkg::OP_STATUS:
                        begin
                            ok_next = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            // one byte written per cycle
            brbcq_pkg::ST_WRITE:
            begin
                mem_we   = 1'b1;
                pos_next = pos_inc;
                cnt_next = cnt_reg + LW'(1);
                if (cnt_reg + LW'(1) == amt_l)
                begin
                    r_next     = pos_inc;
                    state_next = brbcq_pkg::ST_FIN;
                end
            end
            // one byte read per cycle, the data is registered before it lands in its chunk lane
            brbcq_pkg::ST_READ:
            begin
                if (cnt_reg < amt_l)
                begin
                    pos_next  = pos_inc;
                    cnt_next  = cnt_reg + LW'(1);
                    lane_next = cnt_reg;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    for (int i = 0; i < CHUNK_BYTES; i++)
                    begin
                        if (lane_reg == LW'(i))
                        begin
                            chunk_next[i*8 +: 8] = rdata_reg;
                        end
                    end
                end
                if (cnt_reg == amt_l && !pend_reg)
                begin
                    if (cmd_reg.op == brbcq_pkg::OP_DEQ)
                    begin
                        f_next = nidx_reg;
                    end
                    state_next = brbcq_pkg::ST_FIN;
                end
            end
            // amount mod size, one bit per cycle
            brbcq_pkg::ST_MOD:
            begin
                tsum = {rem_reg, cmd_reg.amount[brbcq_pkg::AMT_W - 1 - int'(step_reg)]};
                rem_next = (tsum >= (SW+1)'(size_reg))
                           ? SW'(tsum - (SW+1)'(size_reg)) : SW'(tsum);
                step_next = step_reg + STW'(1);
                if (step_reg == STW'(brbcq_pkg::AMT_W - 1))
                begin
                    state_next = brbcq_pkg::ST_ADD;
                end
            end
            brbcq_pkg::ST_ADD:
            begin
                nsum = (SW+1)'(rem_reg) + ((cmd_reg.op == brbcq_pkg::OP_MOVR)
                       ? (SW+1)'(r_reg) : (SW+1)'(f_reg));
                nwrap = (nsum >= (SW+1)'(size_reg))
                        ? SW'(nsum - (SW+1)'(size_reg)) : SW'(nsum);
                if (cmd_reg.op == brbcq_pkg::OP_MOVR)
                begin
                    r_next = IW'(nwrap);
                end
                else
                begin
                    f_next = IW'(nwrap);
                end
                state_next = brbcq_pkg::ST_FIN;
            end
            // load the result register once it is free
            brbcq_pkg::ST_FIN:
            begin
                if (!outv_reg || pop)
                begin
                    outv_next               = 1'b1;
                    out_next.ok             = ok_reg;
                    out_next.chunk_out      = ok_reg ? chunk_reg : '0;
                    out_next.used_count     = brbcq_pkg::CNT_W'(used);
                    out_next.free_count     = brbcq_pkg::CNT_W'(freeb);
                    out_next.contiguous_get = brbcq_pkg::CNT_W'(span_get);
                    out_next.contiguous_put = brbcq_pkg::CNT_W'(span_put);
                    state_next              = brbcq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brbcq_pkg::ST_IDLE;
            end
        endcase

        // ring size write, clamped, resets the indices
        if (cfg_we)
        begin
            if (CW'(cfg_data) < CW'(2))
            begin
                size_next = SW'(2);
            end
            else if (CW'(cfg_data) > CW'(DEPTH))
            begin
                size_next = SW'(DEPTH);
            end
            else
            begin
                size_next = SW'(cfg_data);
            end
            f_next = '0;
            r_next = IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brbcq_pkg::ST_IDLE;
            f_reg     <= '0;
            r_reg     <= IW'(1);
            size_reg  <= SW'(DEPTH);
            pend_reg  <= 1'b0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            f_reg     <= f_next;
            r_reg     <= r_next;
            size_reg  <= size_next;
            pend_reg  <= pend_next;
            outv_reg  <= outv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        nidx_reg  <= nidx_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        lane_reg  <= lane_next;
        step_reg  <= step_next;
        ok_reg    <= ok_next;
        chunk_reg <= chunk_next;
        out_reg   <= out_next;
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

endmodule

[rtl/byte_ring_buffer_chunk_queue_top.sv]
`timescale 1ns / 1ps

// byte ring buffer with chunk access, one slot always kept empty
// input channel: in_item is taken when push is high and full is low; a
// two-entry command queue sits in front of the execution sequencer
// result channel: out_item is valid while empty is low, taken on pop
// config channel: cfg_data (ring size, clamped to 2..DEPTH) is written when
// cfg_valid and cfg_ready are high; the write also resets both indices
// the sequencer takes one item at a time: enqueue writes its n bytes, dequeue
// and peek read them (n of one or more bytes, one byte store access per cycle)
// with the read data registered, moves reduce the amount mod size bit-serially
// and then add it; clear/status/other, failed and zero-length chunk ops just finish
// throughput is set by the single-port byte store and that sequencer
// reset: front index 0, rear index 1, ring size DEPTH, queues empty; the
// byte store holds no defined value until written
// when the receiver stalls, the result register holds, the sequencer waits
// on the finished item, and the command queue fills before full rises
module byte_ring_buffer_chunk_queue_top #(
    parameter int DEPTH       = brbcq_pkg::DEPTH_DEF,
    parameter int CHUNK_BYTES = brbcq_pkg::CHUNK_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  brbcq_pkg::in_item_t          in_item,
    output logic                         empty,
    input  logic                         pop,
    output brbcq_pkg::out_item_t         out_item,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [brbcq_pkg::CFG_W-1:0]  cfg_data
);

    logic            q_valid, q_pop, back_idle;
    brbcq_pkg::cmd_t q_cmd;

    brbcq_front #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // config taken only when nothing is in flight
    assign cfg_ready = back_idle && !q_valid;

    brbcq_back #(
        .DEPTH       (DEPTH),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .idle     (back_idle),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    // a waiting result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_item))
        else $error("result dropped or changed while waiting");

    // config never accepted while the command queue is full
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !full)
        else $error("config ready with commands pending");

    // a failed op reports no data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !out_item.ok |-> out_item.chunk_out == '0)
        else $error("failed op carries data");

endmodule
